/* hdl/lc3_pkg.sv */
`timescale 1ns / 1ps
// lc3_pkg: shared types, codes and helper functions of the lc3 instruction core
// depends on nothing; imported by every module under hdl

package lc3_pkg;

    // widths
    localparam int DATA_W       = 16;
    localparam int ADDR_BITS_DEF = 16;
    localparam int IN_TDATA_W   = 32;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 80;

    // start address after reset
    localparam logic [DATA_W-1:0] START_RESET = 16'h3000;

    // item modes
    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_EXEC    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // instruction opcodes
    localparam logic [3:0] OP_BR   = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_LD   = 4'd2;
    localparam logic [3:0] OP_ST   = 4'd3;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_LDR  = 4'd6;
    localparam logic [3:0] OP_STR  = 4'd7;
    localparam logic [3:0] OP_NOT  = 4'd9;
    localparam logic [3:0] OP_LDI  = 4'd10;
    localparam logic [3:0] OP_STI  = 4'd11;
    localparam logic [3:0] OP_JMP  = 4'd12;
    localparam logic [3:0] OP_LEA  = 4'd14;
    localparam logic [3:0] OP_TRAP = 4'd15;

    // register that receives the return address of a trap
    localparam logic [2:0] TRAP_LINK_REG = 3'd7;

    // condition codes
    localparam logic [2:0] COND_POS  = 3'b001;
    localparam logic [2:0] COND_ZERO = 3'b010;
    localparam logic [2:0] COND_NEG  = 3'b100;

    // shared alu operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_AND,
        ALU_NOT
    } t_alu_op;

    // one result item, last member in the lowest bits
    typedef struct packed {
        logic              ignored;
        logic [DATA_W-1:0] mem_value;
        logic [DATA_W-1:0] mem_address;
        logic              mem_write;
        logic [DATA_W-1:0] reg_value;
        logic [2:0]        reg_index;
        logic              reg_write;
        logic [3:0]        opcode;
        logic [2:0]        cond;
        logic [DATA_W-1:0] pc;
    } t_result;

    // sign extensions of instruction offsets
    function automatic logic [DATA_W-1:0] sext9(input logic [DATA_W-1:0] ins);
        return {{7{ins[8]}}, ins[8:0]};
    endfunction

    function automatic logic [DATA_W-1:0] sext6(input logic [DATA_W-1:0] ins);
        return {{10{ins[5]}}, ins[5:0]};
    endfunction

    function automatic logic [DATA_W-1:0] sext5(input logic [DATA_W-1:0] ins);
        return {{11{ins[4]}}, ins[4:0]};
    endfunction

    // nzp flags of a written value
    function automatic logic [2:0] cond_of(input logic [DATA_W-1:0] v);
        logic [2:0] c;
        if (v == '0) begin
            c = COND_ZERO;
        end else if (v[DATA_W-1]) begin
            c = COND_NEG;
        end else begin
            c = COND_POS;
        end
        return c;
    endfunction

endpackage

/* hdl/lc3_alu.sv */
`timescale 1ns / 1ps
// lc3_alu: the one 16-bit add / and / not unit shared by the fetch and execute steps of the core
// depends on lc3_pkg

module lc3_alu (
    input  lc3_pkg::t_alu_op            i_op,
    input  logic [lc3_pkg::DATA_W-1:0]  i_a,
    input  logic [lc3_pkg::DATA_W-1:0]  i_b,
    output logic [lc3_pkg::DATA_W-1:0]  o_y
);
    import lc3_pkg::*;

    // operation select
    always_comb begin
        unique case (i_op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_AND: o_y = i_a & i_b;
            ALU_NOT: o_y = ~i_a;
            default: o_y = i_a + i_b;
        endcase
    end

endmodule

/* hdl/lc3_ram.sv */
`timescale 1ns / 1ps
// lc3_ram: single-port word memory with registered read data
// depends on lc3_pkg

module lc3_ram #(
    parameter int ADDR_BITS = lc3_pkg::ADDR_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_BITS-1:0]        i_addr,
    input  logic [lc3_pkg::DATA_W-1:0]  i_wdata,
    output logic [lc3_pkg::DATA_W-1:0]  o_rdata
);
    import lc3_pkg::*;

    logic [DATA_W-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_W-1:0] r_rdata;

    // write port and registered read, old data on a write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/lc3_instruction_core.sv */
`timescale 1ns / 1ps
// lc3_instruction_core: top level, sequencer, register file and output register
// depends on lc3_pkg, lc3_alu and lc3_ram
//
// Usage
//   s_axis: one item per transfer. tuser carries the mode (0 write memory word,
//   1 execute one instruction, 2 reload pc from the start address, 3 no-op).
//   m_axis: one result per item: pc, flags, opcode and any register or memory
//   write. i_cfg_wr_en / i_cfg_wr_data set the start address at any time; pc
//   picks it up only on a mode 2 item; reset loads 0x3000 into both.
// Sequencing
//   Modes 0, 2 and 3: the result is registered on the input transfer.
//   Mode 1: fetch, then execute, then up to two dependent reads, all through
//   the single memory port: register ops, BR, JMP, LEA, ST and STR end after
//   execute; LD, LDR, STI and TRAP add the MEM1 state; LDI adds MEM1 and MEM2.
//   A new item is taken only once the sequencer is back in idle.
// Reset
//   i_rst_n is synchronous. Afterwards a clearing pass writes zero to every
//   memory word, one per cycle, with s_axis_tready low. Registers read zero,
//   pc = 0x3000, flags zero.
// Stall
//   A result waits in the output register until taken; a new item is taken
//   only once that register is empty or being emptied in the same cycle.

module lc3_instruction_core #(
    parameter int ADDR_BITS = lc3_pkg::ADDR_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // start address register
    input  logic                            i_cfg_wr_en,
    input  logic [lc3_pkg::DATA_W-1:0]      i_cfg_wr_data,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: address [15:0], data [31:16]
    input  logic [lc3_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: mode [1:0]
    input  logic [lc3_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: pc [15:0], cond [18:16], opcode [22:19], reg_write [23],
    // reg_index [26:24], reg_value [42:27], mem_write [43],
    // mem_address [59:44], mem_value [75:60], ignored [76], zero [79:77]
    output logic [lc3_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import lc3_pkg::*;

    localparam logic [DATA_W-1:0] ADDR_MASK = DATA_W'((32'd1 << ADDR_BITS) - 32'd1);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_MEM1  = 3'd4;
    localparam logic [2:0] S_MEM2  = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [ADDR_BITS-1:0] r_clr_addr, n_clr_addr;
    logic [DATA_W-1:0]    r_pc, n_pc;
    logic [2:0]           r_cond, n_cond;
    logic [DATA_W-1:0]    r_start;
    logic [DATA_W-1:0]    r_ins;
    logic [DATA_W-1:0]    r_ra, r_rb;
    logic [DATA_W-1:0]    r_rf [8];
    logic [7:0]           r_rf_vld;
    logic                 r_out_valid;
    t_result              r_out, n_out;

    logic                 in_xfer;
    logic                 fin;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [DATA_W-1:0]    mem_wdata;
    logic [DATA_W-1:0]    ram_rdata;
    logic                 rf_we;
    logic                 rf_flags;
    logic [2:0]           rf_idx;
    logic [DATA_W-1:0]    rf_val;
    t_alu_op              alu_op;
    logic [DATA_W-1:0]    alu_a, alu_b, alu_y;
    logic [3:0]           ex_op;
    logic [DATA_W-1:0]    in_addr, in_data;
    logic [DATA_W-1:0]    trap_vec;
    logic [2:0]           rb_idx;

    assign in_addr  = s_axis_tdata[DATA_W-1:0];
    assign in_data  = s_axis_tdata[2*DATA_W-1:DATA_W];
    assign ex_op    = r_ins[15:12];
    assign trap_vec = {8'd0, r_ins[7:0]};

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // shared arithmetic unit
    lc3_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    // word memory
    lc3_ram #(
        .ADDR_BITS (ADDR_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (ram_rdata)
    );

    // sequencer and datapath control
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_pc       = r_pc;
        n_cond     = r_cond;
        n_out      = '0;
        fin        = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = r_pc[ADDR_BITS-1:0];
        mem_wdata  = '0;
        rf_we      = 1'b0;
        rf_flags   = 1'b0;
        rf_idx     = r_ins[11:9];
        rf_val     = alu_y;
        alu_op     = ALU_ADD;
        alu_a      = r_pc;
        alu_b      = DATA_W'(1);

        unique case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_addr   = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (s_axis_tuser)
                        MODE_WRITE: begin
                            mem_we              = 1'b1;
                            mem_addr            = in_addr[ADDR_BITS-1:0];
                            mem_wdata           = in_data;
                            fin                 = 1'b1;
                            n_out.mem_write     = 1'b1;
                            n_out.mem_address   = in_addr & ADDR_MASK;
                            n_out.mem_value     = in_data;
                        end
                        MODE_EXEC: begin
                            n_state = S_FETCH;
                        end
                        MODE_RESTART: begin
                            n_pc = r_start;
                            fin  = 1'b1;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                // instruction word arrives, pc steps by one
                n_pc    = alu_y;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_out.opcode = ex_op;
                fin          = 1'b1;
                n_state      = S_IDLE;
                unique case (ex_op) inside
                    OP_ADD, OP_AND: begin
                        alu_op   = (ex_op == OP_ADD) ? ALU_ADD : ALU_AND;
                        alu_a    = r_ra;
                        alu_b    = r_ins[5] ? sext5(r_ins) : r_rb;
                        rf_we    = 1'b1;
                        rf_flags = 1'b1;
                    end
                    OP_NOT: begin
                        alu_op   = ALU_NOT;
                        alu_a    = r_ra;
                        rf_we    = 1'b1;
                        rf_flags = 1'b1;
                    end
                    OP_BR: begin
                        alu_b = sext9(r_ins);
                        if ((r_ins[11:9] & r_cond) != 3'd0) begin
                            n_pc = alu_y;
                        end
                    end
                    OP_JMP: begin
                        n_pc = r_ra;
                    end
                    OP_LEA: begin
                        alu_b    = sext9(r_ins);
                        rf_we    = 1'b1;
                        rf_flags = 1'b1;
                    end
                    OP_LD, OP_LDI, OP_STI: begin
                        alu_b    = sext9(r_ins);
                        mem_addr = alu_y[ADDR_BITS-1:0];
                        fin      = 1'b0;
                        n_state  = S_MEM1;
                    end
                    OP_LDR: begin
                        alu_a    = r_ra;
                        alu_b    = sext6(r_ins);
                        mem_addr = alu_y[ADDR_BITS-1:0];
                        fin      = 1'b0;
                        n_state  = S_MEM1;
                    end
                    OP_ST, OP_STR: begin
                        if (ex_op == OP_STR) begin
                            alu_a = r_ra;
                            alu_b = sext6(r_ins);
                        end else begin
                            alu_b = sext9(r_ins);
                        end
                        mem_we            = 1'b1;
                        mem_addr          = alu_y[ADDR_BITS-1:0];
                        mem_wdata         = r_rb;
                        n_out.mem_write   = 1'b1;
                        n_out.mem_address = alu_y & ADDR_MASK;
                        n_out.mem_value   = r_rb;
                    end
                    OP_TRAP: begin
                        mem_addr = trap_vec[ADDR_BITS-1:0];
                        fin      = 1'b0;
                        n_state  = S_MEM1;
                    end
                    default: begin
                        // jsr, rti and reserved codes only advance pc
                        n_out.ignored = 1'b1;
                    end
                endcase
            end
            S_MEM1: begin
                n_out.opcode = ex_op;
                fin          = 1'b1;
                n_state      = S_IDLE;
                unique case (ex_op) inside
                    OP_LD, OP_LDR: begin
                        rf_we    = 1'b1;
                        rf_flags = 1'b1;
                        rf_val   = ram_rdata;
                    end
                    OP_LDI: begin
                        mem_addr = ram_rdata[ADDR_BITS-1:0];
                        fin      = 1'b0;
                        n_state  = S_MEM2;
                    end
                    OP_STI: begin
                        mem_we            = 1'b1;
                        mem_addr          = ram_rdata[ADDR_BITS-1:0];
                        mem_wdata         = r_rb;
                        n_out.mem_write   = 1'b1;
                        n_out.mem_address = ram_rdata & ADDR_MASK;
                        n_out.mem_value   = r_rb;
                    end
                    OP_TRAP: begin
                        rf_we  = 1'b1;
                        rf_idx = TRAP_LINK_REG;
                        rf_val = r_pc;
                        n_pc   = ram_rdata;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_MEM2: begin
                n_out.opcode = ex_op;
                fin          = 1'b1;
                n_state      = S_IDLE;
                rf_we        = 1'b1;
                rf_flags     = 1'b1;
                rf_val       = ram_rdata;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register write report and flag update
        if (rf_we) begin
            n_out.reg_write = 1'b1;
            n_out.reg_index = rf_idx;
            n_out.reg_value = rf_val;
            if (rf_flags) begin
                n_cond = cond_of(rf_val);
            end
        end
        n_out.pc   = n_pc;
        n_out.cond = n_cond;
    end

    // second register read port: source for stores, sr2 otherwise
    always_comb begin
        case (ram_rdata[15:12]) inside
            OP_ST, OP_STI, OP_STR: rb_idx = ram_rdata[11:9];
            default:               rb_idx = ram_rdata[2:0];
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_pc        <= START_RESET;
            r_cond      <= '0;
            r_start     <= START_RESET;
            r_out_valid <= 1'b0;
            r_rf_vld    <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_pc       <= n_pc;
            r_cond     <= n_cond;
            if (i_cfg_wr_en) begin
                r_start <= i_cfg_wr_data;
            end
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (rf_we) begin
                r_rf_vld[rf_idx] <= 1'b1;
            end
        end
    end

    // register file, instruction and operand registers, result payload
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_idx] <= rf_val;
        end
        if (r_state == S_FETCH) begin
            r_ins <= ram_rdata;
            r_ra  <= r_rf_vld[ram_rdata[8:6]] ? r_rf[ram_rdata[8:6]] : '0;
            r_rb  <= r_rf_vld[rb_idx] ? r_rf[rb_idx] : '0;
        end
        if (fin) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

endmodule

/* hdl/lc3_checker.sv */
`timescale 1ns / 1ps
// lc3_checker: port-level checks of the lc3 instruction core, bound to the top level
// depends on lc3_pkg and lc3_instruction_core

module lc3_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [lc3_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [lc3_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [lc3_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import lc3_pkg::*;

    // reset starts the clearing pass: no input taken right after
    a_reset_no_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input taken right after reset");

    // reset empties the output register
    a_reset_no_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    // a memory write item reports its word on the next cycle
    a_write_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_WRITE)
        |=> (m_axis_tvalid && m_axis_tdata[43]
             && m_axis_tdata[75:60] == $past(s_axis_tdata[31:16])))
        else $error("memory write transfer not reported");

    // a stalled result stays
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind lc3_instruction_core lc3_checker u_lc3_checker (.*);
